// ===== sv/tpeg_pkg.sv =====
// Shared types, codes and constants for the touch pen event generator.
package tpeg_pkg;

  // Input item kinds
  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_TICK   = 1'b1;

  // Event kinds
  localparam logic [1:0] EV_MOTION  = 2'd0;
  localparam logic [1:0] EV_PRESS   = 2'd1;
  localparam logic [1:0] EV_RELEASE = 2'd2;

  localparam logic [7:0]  RELEASE_TICKS_RESET = 8'd2;
  localparam logic [15:0] COORD_BASE          = 16'h00FF;

  // Result queue geometry (power of two depth)
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef struct packed {
    logic        op;
    logic [15:0] raw_x;
    logic [15:0] raw_y;
  } in_t;

  typedef struct packed {
    logic [1:0]         event_kind;
    logic               button_held;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic               last_of_run;
  } out_t;

  // Events produced by one item, handed from the core to the queue
  typedef struct packed {
    logic [1:0] n;
    out_t       ev0;
    out_t       ev1;
  } push_t;

  // 255 - floor(raw / 2), two's complement in 16 bits
  function automatic logic [15:0] convert(input logic [15:0] raw);
    return 16'(COORD_BASE - {1'b0, raw[15:1]});
  endfunction

endpackage

// ===== sv/tpeg_core.sv =====
// Pen state registers and per-item event generation.
module tpeg_core import tpeg_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       take,
  input  in_t        item,
  input  logic [7:0] release_ticks,
  output push_t      push
);

  logic        pen_down, pen_down_next;
  logic [15:0] prev_x, prev_x_next;
  logic [15:0] prev_y, prev_y_next;
  logic [7:0]  idle_ticks, idle_ticks_next;

  logic [15:0] cx, cy;
  logic [7:0]  tick_count;

  assign cx = convert(item.raw_x);
  assign cy = convert(item.raw_y);
  assign tick_count = idle_ticks + 8'd1;

  always_comb begin
    pen_down_next   = pen_down;
    prev_x_next     = prev_x;
    prev_y_next     = prev_y;
    idle_ticks_next = idle_ticks;
    push            = '0;

    if (item.op == OP_SAMPLE) begin
      if (!pen_down) begin
        push.n   = 2'd2;
        push.ev0 = '{event_kind: EV_MOTION, button_held: 1'b0,
                     pos_x: cx, pos_y: cy, last_of_run: 1'b0};
        push.ev1 = '{event_kind: EV_PRESS, button_held: 1'b1,
                     pos_x: cx, pos_y: cy, last_of_run: 1'b1};
      end else if ((cx != prev_x) && (cy != prev_y)) begin
        push.n   = 2'd1;
        push.ev0 = '{event_kind: EV_MOTION, button_held: 1'b1,
                     pos_x: cx, pos_y: cy, last_of_run: 1'b1};
      end
      prev_x_next     = cx;
      prev_y_next     = cy;
      pen_down_next   = 1'b1;
      idle_ticks_next = '0;
    end else if (pen_down) begin
      idle_ticks_next = tick_count;
      if (tick_count == release_ticks) begin
        push.n        = 2'd1;
        push.ev0      = '{event_kind: EV_RELEASE, button_held: 1'b1,
                          pos_x: '0, pos_y: '0, last_of_run: 1'b1};
        pen_down_next = 1'b0;
      end
    end

    if (!take) begin
      push.n = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pen_down   <= 1'b0;
      prev_x     <= '0;
      prev_y     <= '0;
      idle_ticks <= '0;
    end else if (take) begin
      pen_down   <= pen_down_next;
      prev_x     <= prev_x_next;
      prev_y     <= prev_y_next;
      idle_ticks <= idle_ticks_next;
    end
  end

  // A sample always leaves the pen down
  a_sample_sets_down: assert property (@(posedge clk) disable iff (rst)
    (take && item.op == OP_SAMPLE) |=> pen_down)
    else $error("pen not down after sample");

  // A release only comes from a tick while the pen is down
  a_release_when_down: assert property (@(posedge clk) disable iff (rst)
    (push.n != 2'd0 && push.ev0.event_kind == EV_RELEASE) |-> (pen_down && item.op == OP_TICK))
    else $error("release without pen down");

  // A sample clears the idle tick counter
  a_idle_clear: assert property (@(posedge clk) disable iff (rst)
    (take && item.op == OP_SAMPLE) |=> (idle_ticks == 8'd0))
    else $error("idle counter not cleared by sample");

endmodule

// ===== sv/tpeg_result_fifo.sv =====
// Result queue: up to two writes per cycle, one read per cycle.
module tpeg_result_fifo import tpeg_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  push_t push,
  output logic  room,
  output logic  out_valid,
  input  logic  out_ready,
  output out_t  out_data
);

  out_t              mem [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [QCNT_W-1:0] count, count_next;
  logic              pop;

  assign pop       = out_valid && out_ready;
  assign out_valid = (count != '0);
  assign out_data  = mem[rd_ptr];
  // Room for the largest burst one item can cause
  assign room      = (count <= QCNT_W'(QDEPTH - 2));

  assign count_next = count + QCNT_W'(push.n) - QCNT_W'(pop);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + QPTR_W'(push.n);
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push.n != 2'd0) begin
      mem[wr_ptr] <= push.ev0;
    end
    if (push.n == 2'd2) begin
      mem[wr_ptr + QPTR_W'(1)] <= push.ev1;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    count <= QCNT_W'(QDEPTH))
    else $error("result queue overflow");

  a_push_fits: assert property (@(posedge clk) disable iff (rst)
    (push.n != 2'd0) |-> room)
    else $error("push without room");

  a_count_track: assert property (@(posedge clk) disable iff (rst)
    (push.n == 2'd0 && !pop) |=> $stable(count))
    else $error("queue count moved without transfer");

endmodule

// ===== sv/touch_pen_event_generator_unit.sv =====
// Top level of the touch pen event generator: config register, pen core, result queue.
//
// Turns touch samples and vertical-blank ticks into pointer events. A sample
// while the pen is idle yields motion (no button) then press; a sample while
// the pen is down yields motion only when both coordinates changed; a tick
// while down advances the idle counter and yields a release at 0,0 once it
// equals release_ticks. Rate: one input transfer per cycle while the
// four-entry result queue has room for two events, so a slow output side
// holds the input; each event leaves on its own output transfer, so an
// item with two events takes two output transfers.
// The first event enters the result queue in the cycle after the input transfer.
// release_ticks resets to 2 and is written through the cfg channel, which is
// always ready; write it only while no events are outstanding.
module touch_pen_event_generator_unit import tpeg_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  // input items
  input  logic       in_valid,
  output logic       in_ready,
  input  in_t        in_data,
  // events
  output logic       out_valid,
  input  logic       out_ready,
  output out_t       out_data,
  // release_ticks register
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [7:0] cfg_data
);

  logic [7:0] release_ticks;
  logic       room;
  logic       take;
  push_t      push;

  assign cfg_ready = 1'b1;
  assign in_ready  = room;
  assign take      = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      release_ticks <= RELEASE_TICKS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      release_ticks <= cfg_data;
    end
  end

  // state update and event build for the accepted item
  tpeg_core u_core (
    .clk           (clk),
    .rst           (rst),
    .take          (take),
    .item          (in_data),
    .release_ticks (release_ticks),
    .push          (push)
  );

  // events wait here until the consumer takes them
  tpeg_result_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .room      (room),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// ===== tb/sv/tb.sv =====
// Self-checking testbench for touch_pen_event_generator_unit: random and directed traffic.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import tpeg_pkg::*;

  // What the driver does with the head of its queue
  typedef enum logic [1:0] {
    STEP_ITEM,    // offer one input item
    STEP_WRITE,   // write release_ticks once the block is quiet
    STEP_SETTLE   // hold off until every event has come back
  } step_kind_e;

  typedef struct {
    step_kind_e kind;
    in_t        item;
    logic [7:0] ticks;
    int         send_idle;   // percent of cycles the sender holds back
    int         recv_idle;   // percent of cycles out_ready is low
  } step_t;

  // Output is registered in the cycle after the input transfer; a few spare cycles
  // cover items that produce no event.
  localparam int SETTLE_CYCLES = 4;
  localparam int STALL_LIMIT   = 2000;

  logic       clk       = 1'b0;
  logic       rst       = 1'b1;
  logic       in_valid  = 1'b0;
  logic       in_ready;
  in_t        in_data   = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  out_t       out_data;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [7:0] cfg_data  = '0;

  // Pen state as the testbench sees it
  logic        pen_is_down;
  logic [15:0] last_x;
  logic [15:0] last_y;
  logic [7:0]  tick_count;
  logic [7:0]  release_after;

  out_t  events_due[$];   // events predicted but not yet seen on the output
  step_t steps[$];        // stimulus waiting for the driver

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int quiet_cycles  = 0;
  int stall_cycles  = 0;
  int mismatches    = 0;

  // Idling plan and last raw readings, used while building the stimulus
  int          plan_send;
  int          plan_recv;
  logic [15:0] gen_x = '0;
  logic [15:0] gen_y = '0;

  touch_pen_event_generator_unit dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always #1 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Event prediction
  // ---------------------------------------------------------------------------

  // Screen coordinate: 255 minus half the raw reading, wrapped to 16 bits
  function automatic logic [15:0] to_screen(logic [15:0] raw);
    return 16'(255 - int'(raw >> 1));
  endfunction

  function automatic out_t make_event(logic [1:0] kind, logic btn, logic [15:0] x,
                                      logic [15:0] y, logic last);
    out_t ev;
    ev.event_kind  = kind;
    ev.button_held = btn;
    ev.pos_x       = x;
    ev.pos_y       = y;
    ev.last_of_run = last;
    return ev;
  endfunction

  // Advance the pen state by one accepted item and queue the events it causes
  function automatic void predict_events(in_t it);
    logic [15:0] x;
    logic [15:0] y;
    x = to_screen(it.raw_x);
    y = to_screen(it.raw_y);
    if (it.op == OP_SAMPLE) begin
      if (!pen_is_down) begin
        // pen lands: plain motion first, then press with the button
        events_due.push_back(make_event(EV_MOTION, 1'b0, x, y, 1'b0));
        events_due.push_back(make_event(EV_PRESS, 1'b1, x, y, 1'b1));
      end else if (x != last_x && y != last_y) begin
        // drag is reported only when both axes moved
        events_due.push_back(make_event(EV_MOTION, 1'b1, x, y, 1'b1));
      end
      last_x      = x;
      last_y      = y;
      pen_is_down = 1'b1;
      tick_count  = '0;
    end else if (pen_is_down) begin
      // 8-bit counter; a register below the count is met only after a wrap
      tick_count = tick_count + 8'd1;
      if (tick_count == release_after) begin
        events_due.push_back(make_event(EV_RELEASE, 1'b1, 16'd0, 16'd0, 1'b1));
        pen_is_down = 1'b0;
      end
    end
  endfunction

  function automatic void check_field(string name, logic signed [16:0] want,
                                      logic signed [16:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: input items and register writes, one transfer in flight at a time
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    logic       hold_in;
    logic       hold_cfg;
    logic       settled;
    logic       nxt_in_valid;
    logic       nxt_cfg_valid;
    in_t        nxt_in_data;
    logic [7:0] nxt_cfg_data;
    if (rst) begin
      pen_is_down   = 1'b0;
      last_x        = '0;
      last_y        = '0;
      tick_count    = '0;
      release_after = RELEASE_TICKS_RESET;
      quiet_cycles  = 0;
      in_valid  <= 1'b0;
      cfg_valid <= 1'b0;
    end else begin
      hold_in       = in_valid && !in_ready;
      hold_cfg      = cfg_valid && !cfg_ready;
      nxt_in_valid  = hold_in;
      nxt_cfg_valid = hold_cfg;
      nxt_in_data   = in_data;
      nxt_cfg_data  = cfg_data;

      if (cfg_valid && cfg_ready)
        release_after = cfg_data;
      if (in_valid && in_ready)
        predict_events(in_data);

      // Quiet means no transfer on either data channel for a few cycles. An
      // output transfer this edge restarts the count, so the queue size read
      // below never races with the monitor's pop.
      if ((in_valid && in_ready) || (out_valid && out_ready))
        quiet_cycles = 0;
      else if (quiet_cycles < SETTLE_CYCLES)
        quiet_cycles++;
      settled = (quiet_cycles >= SETTLE_CYCLES) && (events_due.size() == 0);

      if (!hold_in && !hold_cfg && steps.size() != 0) begin
        send_idle_pct <= steps[0].send_idle;
        recv_idle_pct <= steps[0].recv_idle;
        case (steps[0].kind)
          STEP_ITEM: begin
            if ($urandom_range(99) >= send_idle_pct) begin
              nxt_in_valid = 1'b1;
              nxt_in_data  = steps[0].item;
              void'(steps.pop_front());
            end
          end
          STEP_WRITE: begin
            // register is only touched with nothing outstanding
            if (settled) begin
              nxt_cfg_valid = 1'b1;
              nxt_cfg_data  = steps[0].ticks;
              void'(steps.pop_front());
            end
          end
          default: begin
            if (settled)
              void'(steps.pop_front());
          end
        endcase
      end

      in_valid  <= nxt_in_valid;
      in_data   <= nxt_in_data;
      cfg_valid <= nxt_cfg_valid;
      cfg_data  <= nxt_cfg_data;
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: random back-pressure, compare each event with the oldest due
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    out_t want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
      if (out_valid && out_ready) begin
        if (events_due.size() == 0) begin
          $error("event_kind: expected none, got %0d", out_data.event_kind);
          mismatches++;
        end else begin
          want = events_due.pop_front();
          check_field("event_kind", want.event_kind, out_data.event_kind);
          check_field("button_held", want.button_held, out_data.button_held);
          check_field("pos_x", want.pos_x, out_data.pos_x);
          check_field("pos_y", want.pos_y, out_data.pos_y);
          check_field("last_of_run", want.last_of_run, out_data.last_of_run);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog: too long without any transfer ends the run
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
  end

  initial begin
    wait (stall_cycles >= STALL_LIMIT);
    $display("tb: failure");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Stimulus building
  // ---------------------------------------------------------------------------
  task automatic add_item(logic op, logic [15:0] rx, logic [15:0] ry);
    step_t s;
    s.kind       = STEP_ITEM;
    s.item.op    = op;
    s.item.raw_x = rx;
    s.item.raw_y = ry;
    s.ticks      = '0;
    s.send_idle  = plan_send;
    s.recv_idle  = plan_recv;
    steps.push_back(s);
  endtask

  // raw fields of a tick carry junk; the block must ignore them
  task automatic add_tick();
    add_item(OP_TICK, 16'($urandom), 16'($urandom));
  endtask

  task automatic add_write(logic [7:0] ticks);
    step_t s;
    s.kind      = STEP_WRITE;
    s.item      = '0;
    s.ticks     = ticks;
    s.send_idle = plan_send;
    s.recv_idle = plan_recv;
    steps.push_back(s);
  endtask

  task automatic add_settle();
    step_t s;
    s.kind      = STEP_SETTLE;
    s.item      = '0;
    s.ticks     = '0;
    s.send_idle = plan_send;
    s.recv_idle = plan_recv;
    steps.push_back(s);
  endtask

  // Raw reading: often the previous one or its LSB twin (same screen value),
  // so that one-axis and no-axis moves come up; otherwise extremes or random.
  function automatic logic [15:0] pick_raw(logic [15:0] prev);
    case ($urandom_range(0, 7))
      0, 1:    return prev;
      2:       return prev ^ 16'h0001;
      3:       return 16'h0000;
      4:       return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  // Touch bursts followed by tick runs sized around the timeout, so releases
  // happen often; short runs and trailing idle ticks add the odd cases.
  task automatic add_pen_strokes(int budget, int timeout);
    int counted;
    int full;
    int strokes;
    int run;
    counted = 0;
    full    = (timeout == 0) ? 256 : timeout;
    while (counted < budget) begin
      strokes = $urandom_range(1, 4);
      repeat (strokes) begin
        gen_x = pick_raw(gen_x);
        gen_y = pick_raw(gen_y);
        add_item(OP_SAMPLE, gen_x, gen_y);
      end
      case ($urandom_range(0, 3))
        0:       run = full;
        1:       run = full - 1;
        2:       run = $urandom_range(0, full);
        default: run = full + $urandom_range(1, 3);
      endcase
      repeat (run) add_tick();
      // ticks past the release hit an idle pen and do nothing
      counted += strokes + ((run < full) ? run : full);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    int pick;

    // Phase 1: sender idles a little, receiver a lot
    plan_send = 26;
    plan_recv = 70;

    // Directed, timeout at its reset value of 2
    add_tick();                                // tick with pen idle: nothing
    add_item(OP_SAMPLE, 16'h0000, 16'h0000);   // landing at 255,255: motion + press
    add_item(OP_SAMPLE, 16'hFFFF, 16'hFFFF);   // most negative coordinates, both moved
    add_item(OP_SAMPLE, 16'hFFFF, 16'h0000);   // only y moved: no event
    add_item(OP_SAMPLE, 16'h0000, 16'h0000);   // only x moved: no event
    add_item(OP_SAMPLE, 16'h0001, 16'h0001);   // same screen point: no event
    add_item(OP_SAMPLE, 16'h8000, 16'h7FFF);   // both moved: drag
    add_tick();
    add_item(OP_SAMPLE, 16'h8000, 16'h7FFF);   // fresh sample clears the tick count
    add_tick();
    add_tick();                                // second tick after it: release
    add_tick();                                // idle again
    add_item(OP_SAMPLE, 16'hAAAA, 16'h5555);
    add_tick();
    add_tick();                                // release
    add_item(OP_SAMPLE, 16'h5555, 16'hAAAA);
    add_settle();
    add_write(8'd1);                           // shortest timeout
    add_tick();                                // release on first tick
    add_tick();

    add_pen_strokes(170, 1);
    add_write(8'd2);
    add_pen_strokes(80, 2);
    add_settle();                              // sender waits for the output to drain
    pick = $urandom_range(3, 6);
    add_write(8'(pick));
    add_pen_strokes(120, pick);

    // Phase 2: roles swapped
    plan_send = 70;
    plan_recv = 26;
    pick = $urandom_range(1, 8);
    add_write(8'(pick));
    add_pen_strokes(175, pick);
    pick = $urandom_range(1, 8);
    add_write(8'(pick));
    add_pen_strokes(175, pick);

    // Phase 3: no idling on either side
    plan_send = 0;
    plan_recv = 0;

    // Timeout lowered under a running count, to zero: the count wraps and
    // the release comes when it next reads 0 (5 + 251 = 256).
    add_write(8'd10);
    add_item(OP_SAMPLE, 16'($urandom), 16'($urandom));
    repeat (5) add_tick();
    add_write(8'd0);
    repeat (251) add_tick();
    add_tick();                                // pen idle: nothing

    // Largest register value for the timeout
    add_write(8'd255);
    add_item(OP_SAMPLE, 16'($urandom), 16'($urandom));
    repeat (255) add_tick();

    pick = $urandom_range(1, 4);
    add_write(8'(pick));
    add_pen_strokes(80, pick);

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Wait for all stimulus to go out and all events to come back
    do @(negedge clk);
    while (steps.size() != 0 || in_valid || cfg_valid || events_due.size() != 0);
    repeat (2 * SETTLE_CYCLES) @(negedge clk);

    if (events_due.size() != 0)
      $error("event_kind: expected %0d more events, got none", events_due.size());
    if (mismatches == 0 && events_due.size() == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule

// ===== files.f =====
sv/tpeg_pkg.sv
sv/tpeg_core.sv
sv/tpeg_result_fifo.sv
sv/touch_pen_event_generator_unit.sv
tb/sv/tb.sv
